FILE: rtl/piston_cycle_test_sequencer_defines.svh
// ----------------------------------------------------------------------------
// piston cycle test sequencer - assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef PISTON_CYCLE_TEST_SEQUENCER_DEFINES_SVH
`define PISTON_CYCLE_TEST_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define PCTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PCTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pcts_pkg.sv
// ----------------------------------------------------------------------------
// pcts_pkg
// widths, codes and the result record shared by the piston cycle test sequencer
// ----------------------------------------------------------------------------
package pcts_pkg;

	localparam int NOW_WIDTH       = 32;
	localparam int POS_WIDTH       = 2;
	localparam int VALVE_WIDTH     = 2;
	localparam int COUNT_WIDTH     = 25;
	localparam int COUNT_MAX_WIDTH = 24;
	localparam int HOLD_WIDTH      = 16;
	localparam int ERR_RUN_WIDTH   = 4;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 24;

	localparam int ERROR_LIMIT_DEF = 10;
	localparam int TIME_WIDTH_DEF  = 32;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COUNT_MAX = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TIME = 1'b1;

	localparam logic [POS_WIDTH-1:0] POS_TOP    = 2'd1;
	localparam logic [POS_WIDTH-1:0] POS_BOTTOM = 2'd2;

	localparam logic [VALVE_WIDTH-1:0] VALVE_NONE = 2'd0;
	localparam logic [VALVE_WIDTH-1:0] VALVE_UP   = 2'd1;
	localparam logic [VALVE_WIDTH-1:0] VALVE_DOWN = 2'd2;

	typedef struct packed {
		logic [VALVE_WIDTH-1:0] valve_command;
		logic                   report_valid;
		logic                   run_finished;
		logic [COUNT_WIDTH-1:0] cycle_count;
		logic [COUNT_WIDTH-1:0] miss_count;
	} pcts_result_t;

endpackage

FILE: rtl/piston_cycle_test_sequencer.sv
// ----------------------------------------------------------------------------
// piston_cycle_test_sequencer
// piston up/down endurance test sequencer, one result per poll
// ----------------------------------------------------------------------------
// Takes one poll transaction per clock while in_stall is low and returns
// exactly one result transaction per poll. A poll is captured in the input
// register, the step logic runs on it and the result lands in the output
// register once the output side is free, so the sustained rate is one poll
// per clock while out_stall stays low. The output register frees the input
// side: a new poll is taken while a finished result still waits on
// out_stall. Configuration writes are always ready and take effect at once;
// write them only with no poll in flight. No clearing pass follows reset.
`include "piston_cycle_test_sequencer_defines.svh"

module piston_cycle_test_sequencer #(
	parameter int ERROR_LIMIT = pcts_pkg::ERROR_LIMIT_DEF,
	parameter int TIME_WIDTH  = pcts_pkg::TIME_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pcts_pkg::NOW_WIDTH-1:0]        now_ms,
	input  logic [pcts_pkg::POS_WIDTH-1:0]        piston_position,
	input  logic                                  current_present,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pcts_pkg::VALVE_WIDTH-1:0]      valve_command,
	output logic                                  report_valid,
	output logic                                  run_finished,
	output logic [pcts_pkg::COUNT_WIDTH-1:0]      cycle_count,
	output logic [pcts_pkg::COUNT_WIDTH-1:0]      miss_count,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pcts_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [pcts_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import pcts_pkg::*;

	logic [COUNT_MAX_WIDTH-1:0] count_max_q;
	logic [HOLD_WIDTH-1:0]      hold_time_q;

	logic                       valid_s1;
	logic [TIME_WIDTH-1:0]      now_s1;
	logic [POS_WIDTH-1:0]       pos_s1;
	logic                       current_s1;

	logic                       valid_s2;
	pcts_result_t               result_s2;
	pcts_result_t               step_result;

	logic                       advance;
	logic                       in_take;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_max_q <= '0;
			hold_time_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COUNT_MAX: count_max_q <= cfg_data[COUNT_MAX_WIDTH-1:0];
				REG_HOLD_TIME: hold_time_q <= cfg_data[HOLD_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1     <= now_ms[TIME_WIDTH-1:0];
			pos_s1     <= piston_position;
			current_s1 <= current_present;
		end
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	pcts_core #(
		.ERROR_LIMIT (ERROR_LIMIT),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.now       (now_s1),
		.pos       (pos_s1),
		.current   (current_s1),
		.count_max (count_max_q),
		.hold_time (hold_time_q),
		.result    (step_result)
	);

	assign out_valid     = valid_s2;
	assign valve_command = result_s2.valve_command;
	assign report_valid  = result_s2.report_valid;
	assign run_finished  = result_s2.run_finished;
	assign cycle_count   = result_s2.cycle_count;
	assign miss_count    = result_s2.miss_count;

	`PCTS_ASSERT_IMPL(a_report_is_push_up, out_valid && report_valid, valve_command == VALVE_UP && !run_finished, "report without push-up")
	`PCTS_ASSERT_NEXT(a_waiting_poll_kept, valid_s1 && !advance, valid_s1, "waiting poll dropped")
	`PCTS_ASSERT_NEXT(a_result_from_step, advance, valid_s2, "step produced no result")

endmodule

FILE: rtl/pcts_core.sv
// ----------------------------------------------------------------------------
// pcts_core
// sequencer state and the combinational step logic for one poll
// ----------------------------------------------------------------------------
`include "piston_cycle_test_sequencer_defines.svh"

module pcts_core #(
	parameter int ERROR_LIMIT = pcts_pkg::ERROR_LIMIT_DEF,
	parameter int TIME_WIDTH  = pcts_pkg::TIME_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   step_en,
	input  logic [TIME_WIDTH-1:0]                  now,
	input  logic [pcts_pkg::POS_WIDTH-1:0]         pos,
	input  logic                                   current,
	input  logic [pcts_pkg::COUNT_MAX_WIDTH-1:0]   count_max,
	input  logic [pcts_pkg::HOLD_WIDTH-1:0]        hold_time,
	output pcts_pkg::pcts_result_t                 result
);
	import pcts_pkg::*;

	localparam logic [ERR_RUN_WIDTH-1:0] ERR_LIMIT = ERR_RUN_WIDTH'(ERROR_LIMIT);

	typedef enum logic [2:0] {
		PH_PUSH_UP,
		PH_WAIT_TOP,
		PH_PUSH_DOWN,
		PH_WAIT_BOTTOM,
		PH_CHECK_CURRENT
	} phase_t;

	phase_t                   phase_q, phase_nxt;
	logic [TIME_WIDTH-1:0]    start_q, start_nxt;
	logic [COUNT_WIDTH-1:0]   cycles_q, cycles_nxt;
	logic [COUNT_WIDTH-1:0]   misses_q, misses_nxt;
	logic [ERR_RUN_WIDTH-1:0] error_run_q, error_run_nxt;
	logic                     settle_q, settle_nxt;

	logic [TIME_WIDTH-1:0]    elapsed;
	logic                     timed_out;
	logic [ERR_RUN_WIDTH-1:0] err_inc;
	logic                     err_hit;
	logic                     run_active;

	// wrap-around difference over the timestamp width
	assign elapsed    = now - start_q;
	assign timed_out  = elapsed > TIME_WIDTH'(hold_time);
	assign err_inc    = error_run_q + ERR_RUN_WIDTH'(1);
	assign err_hit    = err_inc >= ERR_LIMIT;
	assign run_active = cycles_q <= COUNT_WIDTH'(count_max);

	always_comb begin
		phase_nxt            = phase_q;
		start_nxt            = start_q;
		cycles_nxt           = cycles_q;
		misses_nxt           = misses_q;
		error_run_nxt        = error_run_q;
		settle_nxt           = settle_q;
		result.valve_command = VALVE_NONE;
		result.report_valid  = 1'b0;
		result.run_finished  = 1'b0;
		if (run_active) begin
			case (phase_q)
				PH_PUSH_UP: begin
					result.report_valid  = 1'b1;
					result.valve_command = VALVE_UP;
					start_nxt            = now;
					phase_nxt            = PH_WAIT_TOP;
				end
				PH_WAIT_TOP: begin
					if (timed_out) begin
						start_nxt = '0;
						if (pos == POS_TOP) begin
							phase_nxt = PH_PUSH_DOWN;
						end else begin
							phase_nxt           = PH_PUSH_UP;
							error_run_nxt       = err_hit ? '0 : err_inc;
							result.run_finished = err_hit;
						end
					end
				end
				PH_PUSH_DOWN: begin
					result.valve_command = VALVE_DOWN;
					start_nxt            = now;
					phase_nxt            = PH_WAIT_BOTTOM;
				end
				PH_WAIT_BOTTOM: begin
					if (pos == POS_BOTTOM) begin
						phase_nxt = PH_CHECK_CURRENT;
					end else if (timed_out) begin
						cycles_nxt          = cycles_q + COUNT_WIDTH'(1);
						misses_nxt          = misses_q + COUNT_WIDTH'(1);
						start_nxt           = '0;
						phase_nxt           = PH_PUSH_UP;
						error_run_nxt       = err_hit ? '0 : err_inc;
						result.run_finished = err_hit;
					end
				end
				PH_CHECK_CURRENT: begin
					// first poll here only starts the settle timer
					if (!settle_q) begin
						start_nxt  = now;
						settle_nxt = 1'b1;
					end else if (timed_out) begin
						if (!current) begin
							misses_nxt = misses_q + COUNT_WIDTH'(1);
						end
						cycles_nxt = cycles_q + COUNT_WIDTH'(1);
						phase_nxt  = PH_PUSH_UP;
						start_nxt  = '0;
						settle_nxt = 1'b0;
					end
				end
				default: begin
					phase_nxt = PH_PUSH_UP;
				end
			endcase
		end else begin
			cycles_nxt          = '0;
			misses_nxt          = '0;
			result.run_finished = 1'b1;
		end
		result.cycle_count = cycles_nxt;
		result.miss_count  = misses_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PUSH_UP;
			start_q     <= '0;
			cycles_q    <= '0;
			misses_q    <= '0;
			error_run_q <= '0;
			settle_q    <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_nxt;
			start_q     <= start_nxt;
			cycles_q    <= cycles_nxt;
			misses_q    <= misses_nxt;
			error_run_q <= error_run_nxt;
			settle_q    <= settle_nxt;
		end
	end

	`PCTS_ASSERT_IMPL(a_err_run_below_limit, 1'b1, error_run_q < ERR_LIMIT, "error run at limit")
	`PCTS_ASSERT_IMPL(a_settle_in_check, settle_q, phase_q == PH_CHECK_CURRENT, "settle outside check")
	`PCTS_ASSERT_NEXT(a_state_held_idle, !step_en, phase_q == $past(phase_q) && cycles_q == $past(cycles_q), "state moved without a step")

endmodule
